// ===== rtl/mswdt_pkg.sv =====
`default_nettype none

package mswdt_pkg;

  // Sizing of the timer
  localparam int STAGE_COUNT  = 2;
  localparam int COUNT_BITS   = 63;
  localparam int DIVIDER_BITS = 16;

  // Bus fields
  localparam int DATA_BITS  = 64;
  localparam int OFF_BITS   = 6;
  localparam int CODE_BITS  = 16;
  localparam int FLAG_BITS  = 2;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  // Register map
  localparam logic [OFF_BITS-1:0] OFF_CONFIG   = 6'h20;
  localparam logic [OFF_BITS-1:0] OFF_STATUS   = 6'h24;
  localparam logic [OFF_BITS-1:0] OFF_ARM      = 6'h28;
  localparam logic [OFF_BITS-1:0] OFF_FIRE     = 6'h2c;
  localparam logic [3:0]          SUB_TERMINAL = 4'h0;
  localparam logic [3:0]          SUB_COUNT    = 4'h8;
  localparam int                  CFG_DIV_LSB  = 2;

  // Arm codes run from ARM_BASE upward; the last one is the disable command
  localparam logic [CODE_BITS-1:0] ARM_BASE  = 16'hCD01;
  localparam int                   NUM_CODES = 7;
  localparam int                   HALT_IDX  = 6;
  localparam int                   KIND_CAPTURE = 0;
  localparam int                   KIND_LOAD    = 1;
  localparam int                   KIND_CLEAR   = 2;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Command strobes decoded from an accepted fire
  typedef struct packed {
    logic [STAGE_COUNT-1:0] capture;
    logic [STAGE_COUNT-1:0] load;
    logic [STAGE_COUNT-1:0] clear;
    logic                   halt;
  } op_t;

endpackage

`default_nettype wire

// ===== rtl/mswdt_req_if.sv =====
`default_nettype none

interface mswdt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [5:0]  reg_offset;
  logic [63:0] write_value;

  modport source (output valid, output cmd, output reg_offset, output write_value,
                  input ready);
  modport sink   (input valid, input cmd, input reg_offset, input write_value,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/mswdt_rsp_if.sv =====
`default_nettype none

interface mswdt_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] read_value;
  logic [1:0]  timeout_flags;
  logic        is_enabled;
  logic        fire_rejected;

  modport source (output valid, output read_value, output timeout_flags,
                  output is_enabled, output fire_rejected, input ready);
  modport sink   (input valid, input read_value, input timeout_flags,
                  input is_enabled, input fire_rejected, output ready);
endinterface

`default_nettype wire

// ===== rtl/mswdt_fire.sv =====
`default_nettype none

module mswdt_fire (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             arm_en,
  input  wire logic                             fire_en,
  input  wire logic [mswdt_pkg::CODE_BITS-1:0]  wr_code,
  output mswdt_pkg::op_t                        op,
  output logic                                  rejected
);

  logic [mswdt_pkg::CODE_BITS-1:0] armed_code;
  logic                            armed_valid;
  logic [mswdt_pkg::CODE_BITS-1:0] swapped;
  logic                            match;
  logic                            known;
  mswdt_pkg::op_t                  op_raw;

  // Hold the armed code; every fire consumes it
  always_ff @(posedge clk) begin
    if (rst) begin
      armed_code  <= '0;
      armed_valid <= 1'b0;
    end else if (arm_en) begin
      armed_code  <= wr_code;
      armed_valid <= 1'b1;
    end else if (fire_en) begin
      armed_valid <= 1'b0;
    end
  end

  assign swapped = {armed_code[7:0], armed_code[15:8]};
  assign match   = armed_valid && (wr_code == swapped);

  // Decode the armed code into one command strobe
  always_comb begin
    op_raw = '0;
    known  = 1'b0;
    for (int j = 0; j < mswdt_pkg::NUM_CODES; j++) begin
      if (armed_code == mswdt_pkg::ARM_BASE + mswdt_pkg::CODE_BITS'(j)) begin
        if (j == mswdt_pkg::HALT_IDX) begin
          op_raw.halt = 1'b1;
          known       = 1'b1;
        end else if ((j % 2) < mswdt_pkg::STAGE_COUNT) begin
          known = 1'b1;
          case (j / 2)
            mswdt_pkg::KIND_CAPTURE: op_raw.capture[j % 2] = 1'b1;
            mswdt_pkg::KIND_LOAD:    op_raw.load[j % 2]    = 1'b1;
            default:                 op_raw.clear[j % 2]   = 1'b1;
          endcase
        end
      end
    end
  end

  // Run the command only on a matching fire of a known code
  assign op       = (fire_en && match && known) ? op_raw : '0;
  assign rejected = fire_en && !(match && known);

endmodule

`default_nettype wire

// ===== rtl/multistage_watchdog_timer.sv =====
`default_nettype none

// Channel  Role    Payload
// req      sink    cmd[1:0], reg_offset[5:0], write_value[63:0]
// rsp      source  read_value[63:0], timeout_flags[1:0], is_enabled, fire_rejected
//
// One request per cycle while responses are taken; its response passes the input register,
// then the result register, set by the single update pass.
// Synchronous active-high reset clears all timer, register and arm state, leaving stage 0 running.
// A stalled response holds; one more request waits in the input register,
// after which req.ready drops until the response is taken.

module multistage_watchdog_timer (
  input wire logic  clk,
  input wire logic  rst,
  mswdt_req_if.sink req,
  mswdt_rsp_if.source rsp
);

  localparam int N  = mswdt_pkg::STAGE_COUNT;
  localparam int CB = mswdt_pkg::COUNT_BITS;
  localparam int DB = mswdt_pkg::DIVIDER_BITS;

  // Input register
  logic                             in_valid;
  logic [1:0]                       in_cmd;
  logic [mswdt_pkg::OFF_BITS-1:0]   in_off;
  logic [mswdt_pkg::DATA_BITS-1:0]  in_val;

  // Result register
  logic                             out_valid;
  logic [mswdt_pkg::DATA_BITS-1:0]  read_value;
  logic [mswdt_pkg::FLAG_BITS-1:0]  timeout_flags;
  logic                             is_enabled;
  logic                             fire_rejected;

  // Timer state
  logic                      enable_bit, enable_bit_next;
  logic [DB-1:0]             tick_divider, tick_divider_next;
  logic [DB-1:0]             prescale_count, prescale_count_next;
  logic [mswdt_pkg::DATA_BITS-1:0] terminal_staged [N];
  logic [mswdt_pkg::DATA_BITS-1:0] terminal_staged_next [N];
  logic [CB-1:0]             terminal_active [N];
  logic [CB-1:0]             terminal_active_next [N];
  logic [CB-1:0]             stage_count [N];
  logic [CB-1:0]             stage_count_next [N];
  logic [CB-1:0]             count_snapshot [N];
  logic [CB-1:0]             count_snapshot_next [N];
  logic [N-1:0]              stage_running, stage_running_next;
  logic [N-1:0]              timeout_status, timeout_status_next;

  logic                      out_free;
  logic                      take;
  logic                      is_write;
  logic                      arm_en;
  logic                      fire_en;
  logic                      fire_rej;
  mswdt_pkg::op_t            op;
  logic [DB:0]               pre_inc;
  logic [DB-1:0]             div_eff;
  logic [N-1:0]              was_running;
  logic [CB-1:0]             cnt_work;
  logic [mswdt_pkg::DATA_BITS-1:0] rd_next;

  assign out_free  = !out_valid || rsp.ready;
  assign take      = in_valid && out_free;
  assign req.ready = !in_valid || out_free;

  // Capture a request
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_cmd <= req.cmd;
      in_off <= req.reg_offset;
      in_val <= req.write_value;
    end
  end

  assign is_write = in_cmd == mswdt_pkg::CMD_WRITE;
  assign arm_en   = take && is_write && (in_off == mswdt_pkg::OFF_ARM);
  assign fire_en  = take && is_write && (in_off == mswdt_pkg::OFF_FIRE);

  mswdt_fire u_fire (
    .clk      (clk),
    .rst      (rst),
    .arm_en   (arm_en),
    .fire_en  (fire_en),
    .wr_code  (in_val[mswdt_pkg::CODE_BITS-1:0]),
    .op       (op),
    .rejected (fire_rej)
  );

  // Work out the next timer state and the response for the held request
  always_comb begin
    enable_bit_next      = enable_bit;
    tick_divider_next    = tick_divider;
    prescale_count_next  = prescale_count;
    terminal_staged_next = terminal_staged;
    terminal_active_next = terminal_active;
    stage_count_next     = stage_count;
    count_snapshot_next  = count_snapshot;
    stage_running_next   = stage_running;
    timeout_status_next  = timeout_status;
    rd_next              = '0;
    was_running          = stage_running;
    pre_inc              = {1'b0, prescale_count} + (DB + 1)'(1);
    div_eff              = (tick_divider == '0) ? DB'(1) : tick_divider;
    cnt_work             = '0;

    case (mswdt_pkg::cmd_t'(in_cmd))
      mswdt_pkg::CMD_TICK: begin
        if (enable_bit) begin
          if (pre_inc < {1'b0, div_eff}) begin
            prescale_count_next = pre_inc[DB-1:0];
          end else begin
            prescale_count_next = '0;
            // Advance the running stage; a timeout of any but the last stage hands over to the next one
            for (int s = 0; s < N; s++) begin
              if (was_running[s]) begin
                cnt_work = (stage_count_next[s] != mswdt_pkg::COUNT_MAX) ?
                           stage_count_next[s] + CB'(1) : stage_count_next[s];
                stage_count_next[s] = cnt_work;
                if (cnt_work >= terminal_active[s]) begin
                  timeout_status_next[s] = 1'b1;
                  stage_running_next[s]  = 1'b0;
                  if (s + 1 < N) begin
                    stage_running_next[(s + 1) % N] = 1'b1;
                    stage_count_next[(s + 1) % N]   = '0;
                  end
                end
              end
            end
          end
        end
      end

      mswdt_pkg::CMD_WRITE: begin
        for (int s = 0; s < N; s++) begin
          if (in_off[5:4] == 2'(s) && in_off[3:0] == mswdt_pkg::SUB_TERMINAL) begin
            terminal_staged_next[s] = in_val;
          end
        end
        if (in_off == mswdt_pkg::OFF_CONFIG) begin
          if (in_val[0]) begin
            enable_bit_next = 1'b1;
          end
          tick_divider_next = in_val[mswdt_pkg::CFG_DIV_LSB +: DB];
        end
        if (in_off == mswdt_pkg::OFF_STATUS) begin
          timeout_status_next = timeout_status & in_val[N-1:0];
        end
        // Apply a command from an accepted fire
        for (int s = 0; s < N; s++) begin
          if (op.capture[s]) begin
            count_snapshot_next[s] = stage_count[s];
          end
          if (op.load[s]) begin
            terminal_active_next[s] = terminal_staged[s][CB-1:0];
          end
          if (op.clear[s]) begin
            stage_count_next[s] = '0;
          end
        end
        if (op.clear[0]) begin
          stage_running_next[0] = 1'b1;
          for (int t = 1; t < N; t++) begin
            stage_running_next[t] = 1'b0;
            stage_count_next[t]   = '0;
          end
        end
        if (op.halt) begin
          enable_bit_next = 1'b0;
        end
      end

      mswdt_pkg::CMD_READ: begin
        for (int s = 0; s < N; s++) begin
          if (in_off[5:4] == 2'(s)) begin
            if (in_off[3:0] == mswdt_pkg::SUB_TERMINAL) begin
              rd_next = terminal_staged[s];
            end else if (in_off[3:0] == mswdt_pkg::SUB_COUNT) begin
              rd_next = mswdt_pkg::DATA_BITS'(count_snapshot[s]);
            end
          end
        end
        if (in_off == mswdt_pkg::OFF_CONFIG) begin
          rd_next = mswdt_pkg::DATA_BITS'({tick_divider, 1'b0, enable_bit});
        end else if (in_off == mswdt_pkg::OFF_STATUS) begin
          rd_next = mswdt_pkg::DATA_BITS'(timeout_status);
        end
      end

      default: ;
    endcase
  end

  // Commit the timer state
  always_ff @(posedge clk) begin
    if (rst) begin
      enable_bit     <= 1'b0;
      tick_divider   <= '0;
      prescale_count <= '0;
      for (int s = 0; s < N; s++) begin
        terminal_staged[s] <= '0;
        terminal_active[s] <= '0;
        stage_count[s]     <= '0;
        count_snapshot[s]  <= '0;
      end
      stage_running  <= N'(1);
      timeout_status <= '0;
    end else if (take) begin
      enable_bit      <= enable_bit_next;
      tick_divider    <= tick_divider_next;
      prescale_count  <= prescale_count_next;
      terminal_staged <= terminal_staged_next;
      terminal_active <= terminal_active_next;
      stage_count     <= stage_count_next;
      count_snapshot  <= count_snapshot_next;
      stage_running   <= stage_running_next;
      timeout_status  <= timeout_status_next;
    end
  end

  // Hold the response until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      read_value    <= rd_next;
      timeout_flags <= mswdt_pkg::FLAG_BITS'(timeout_status_next);
      is_enabled    <= enable_bit_next;
      fire_rejected <= fire_rej;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.read_value    = read_value;
  assign rsp.timeout_flags = timeout_flags;
  assign rsp.is_enabled    = is_enabled;
  assign rsp.fire_rejected = fire_rejected;

  // At most one stage runs at a time
  a_one_running: assert property (@(posedge clk) disable iff (rst)
    $onehot0(stage_running))
    else $error("more than one watchdog stage running");

  // Input backs up only behind a stalled response
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> (rsp.valid && !rsp.ready))
    else $error("request stalled without a stalled response");

  // Reset leaves the watchdog disabled
  a_reset_disabled: assert property (@(posedge clk)
    rst |=> !enable_bit)
    else $error("watchdog enabled after reset");

endmodule

`default_nettype wire

// ===== bench/tb_multistage_watchdog_timer.sv =====
`timescale 1ns / 1ps

module tb_multistage_watchdog_timer;
  import mswdt_pkg::*;

  localparam logic [1:0] CMD_NONE     = 2'd3;
  localparam logic [5:0] OFF_UNMAPPED = 6'h2f;
  localparam int         QUIET_LIMIT  = 2000;
  localparam int         PHASE_ITEMS  = 375;

  typedef struct packed {
    logic [63:0] read_value;
    logic [1:0]  timeout_flags;
    logic        is_enabled;
    logic        fire_rejected;
  } wdt_rsp_t;

  logic clk = 1'b0;
  logic rst;

  mswdt_req_if req_bus ();
  mswdt_rsp_if rsp_bus ();

  multistage_watchdog_timer i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predicted timer state
  logic                  m_enable;
  logic [15:0]           m_divider;
  int unsigned           m_prescale;
  logic [63:0]           m_term_staged [STAGE_COUNT];
  logic [COUNT_BITS-1:0] m_term_active [STAGE_COUNT];
  logic [COUNT_BITS-1:0] m_count       [STAGE_COUNT];
  logic [COUNT_BITS-1:0] m_snap        [STAGE_COUNT];
  logic [STAGE_COUNT-1:0] m_running;
  logic [1:0]            m_status;
  logic [15:0]           m_armed_code;
  logic                  m_armed;

  wdt_rsp_t pending_rsp [$];

  int idle_pct = 0;
  int stall_pct = 0;
  int fail_count = 0;
  int checked_count = 0;
  int tick_count = 0;
  int write_count = 0;
  int read_count = 0;
  int sent_count = 0;
  int fires_run = 0;
  int fires_rejected = 0;
  int stage_timeouts = 0;
  int quiet_cycles = 0;

  function automatic logic [15:0] byte_swap(input logic [15:0] c);
    return {c[7:0], c[15:8]};
  endfunction

  function automatic logic [5:0] stage_off(input int s, input logic [3:0] sub);
    return 6'(s * 16) | 6'(sub);
  endfunction

  // Advance the predicted state by one request and return its response
  function automatic wdt_rsp_t predict_watchdog(input logic [1:0] cmd, input logic [5:0] off,
                                                input logic [63:0] val);
    wdt_rsp_t r;
    logic [1:0] st;
    logic [3:0] sub;
    logic reg_hit;
    logic was_armed;
    logic [STAGE_COUNT-1:0] was_running;
    int unsigned div;
    int idx;
    int s;
    int kind;
    r = '0;
    st = off[5:4];
    sub = off[3:0];
    reg_hit = (off < OFF_CONFIG) && (int'(st) < STAGE_COUNT);
    case (cmd)
      CMD_TICK: begin
        if (m_enable) begin
          div = (m_divider == 16'd0) ? 1 : int'(m_divider);
          m_prescale++;
          if (m_prescale >= div) begin
            m_prescale = 0;
            was_running = m_running;
            for (s = 0; s < STAGE_COUNT; s++) begin
              if (was_running[s]) begin
                if (m_count[s] != COUNT_MAX) m_count[s] = m_count[s] + 1'b1;
                if (m_count[s] >= m_term_active[s]) begin
                  m_status[s] = 1'b1;
                  m_running[s] = 1'b0;
                  stage_timeouts++;
                  if (s + 1 < STAGE_COUNT) begin
                    m_running[s+1] = 1'b1;
                    m_count[s+1] = '0;
                  end
                end
              end
            end
          end
        end
      end
      CMD_WRITE: begin
        if (reg_hit && sub == SUB_TERMINAL) begin
          m_term_staged[st] = val;
        end else if (off == OFF_CONFIG) begin
          if (val[0]) m_enable = 1'b1;
          m_divider = val[CFG_DIV_LSB +: DIVIDER_BITS];
        end else if (off == OFF_STATUS) begin
          m_status = m_status & val[1:0];
        end else if (off == OFF_ARM) begin
          m_armed_code = val[15:0];
          m_armed = 1'b1;
        end else if (off == OFF_FIRE) begin
          // Every fire consumes the arm, matched or not
          was_armed = m_armed;
          m_armed = 1'b0;
          idx = int'(m_armed_code) - int'(ARM_BASE);
          s = idx % 2;
          kind = idx / 2;
          if (!was_armed || val[15:0] != byte_swap(m_armed_code) || idx < 0 ||
              idx >= NUM_CODES || (idx != HALT_IDX && s >= STAGE_COUNT)) begin
            r.fire_rejected = 1'b1;
            fires_rejected++;
          end else begin
            fires_run++;
            if (idx == HALT_IDX) begin
              m_enable = 1'b0;
            end else if (kind == KIND_CAPTURE) begin
              m_snap[s] = m_count[s];
            end else if (kind == KIND_LOAD) begin
              m_term_active[s] = m_term_staged[s][COUNT_BITS-1:0];
            end else begin
              // Clear; a kick of stage 0 also restarts the chain
              m_count[s] = '0;
              if (s == 0) begin
                m_running[0] = 1'b1;
                for (int t = 1; t < STAGE_COUNT; t++) begin
                  m_running[t] = 1'b0;
                  m_count[t] = '0;
                end
              end
            end
          end
        end
      end
      CMD_READ: begin
        if (reg_hit && sub == SUB_TERMINAL) r.read_value = m_term_staged[st];
        else if (reg_hit && sub == SUB_COUNT) r.read_value = 64'(m_snap[st]);
        else if (off == OFF_CONFIG)
          r.read_value = (64'(m_divider) << CFG_DIV_LSB) | 64'(m_enable);
        else if (off == OFF_STATUS) r.read_value = 64'(m_status);
      end
      default: ;
    endcase
    r.timeout_flags = m_status;
    r.is_enabled = m_enable;
    return r;
  endfunction

  // Drive one request, hold it until accepted, then queue its response
  task automatic send_req(input logic [1:0] cmd, input logic [5:0] off, input logic [63:0] val);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_bus.valid <= 1'b1;
    req_bus.cmd <= cmd;
    req_bus.reg_offset <= off;
    req_bus.write_value <= val;
    @(posedge clk);
    while (req_bus.ready !== 1'b1) @(posedge clk);
    pending_rsp.push_back(predict_watchdog(cmd, off, val));
    sent_count++;
    if (cmd == CMD_TICK) tick_count++;
    else if (cmd == CMD_WRITE) write_count++;
    else if (cmd == CMD_READ) read_count++;
  endtask

  // Arm a command and fire it with the matching swapped code
  task automatic issue_command(input int idx);
    logic [15:0] code;
    code = 16'(ARM_BASE + idx);
    send_req(CMD_WRITE, OFF_ARM, 64'(code));
    send_req(CMD_WRITE, OFF_FIRE, {$urandom, 16'($urandom), byte_swap(code)});
  endtask

  task automatic test_register_access();
    send_req(CMD_WRITE, stage_off(0, SUB_TERMINAL), '1);
    send_req(CMD_READ, stage_off(0, SUB_TERMINAL), '0);
    send_req(CMD_WRITE, stage_off(1, SUB_TERMINAL), 64'h8000_0000_0000_0001);
    // Largest divider, then divider zero; writing zero to enable leaves it set
    send_req(CMD_WRITE, OFF_CONFIG, (64'hFFFF << CFG_DIV_LSB) | 64'd1);
    send_req(CMD_READ, OFF_CONFIG, '0);
    send_req(CMD_TICK, '0, '0);
    send_req(CMD_WRITE, OFF_CONFIG, '0);
    send_req(CMD_READ, OFF_CONFIG, '0);
  endtask

  // Zero terminals: stage 0 times out, then the last stage does
  task automatic test_timeout_chain();
    send_req(CMD_TICK, '0, '0);
    send_req(CMD_TICK, '1, '1);
    send_req(CMD_READ, OFF_STATUS, '0);
    send_req(CMD_WRITE, OFF_STATUS, 64'h2);
  endtask

  task automatic test_commands();
    issue_command(KIND_CAPTURE * 2);
    send_req(CMD_READ, stage_off(0, SUB_COUNT), '0);
    issue_command(KIND_LOAD * 2);
    issue_command(KIND_CLEAR * 2);
    send_req(CMD_TICK, '0, '0);
    issue_command(HALT_IDX);
    send_req(CMD_TICK, '0, '0);
  endtask

  task automatic test_rejected_fires();
    send_req(CMD_WRITE, OFF_FIRE, 64'(byte_swap(16'(ARM_BASE + KIND_LOAD * 2))));
    send_req(CMD_WRITE, OFF_ARM, 64'(16'(ARM_BASE + KIND_LOAD * 2)));
    send_req(CMD_WRITE, OFF_FIRE, 64'h1234);
    send_req(CMD_WRITE, OFF_ARM, 64'h1234);
    send_req(CMD_WRITE, OFF_FIRE, 64'h3412);
  endtask

  task automatic test_ignored_accesses();
    send_req(CMD_NONE, OFF_CONFIG, '1);
    send_req(CMD_READ, OFF_FIRE, '0);
    send_req(CMD_WRITE, stage_off(1, SUB_COUNT), '1);
    send_req(CMD_WRITE, OFF_UNMAPPED, '1);
  endtask

  // Mostly well-formed traffic with random content, plus broken sequences and noise
  task automatic random_traffic(input int n_items);
    int start;
    int pick;
    int s;
    int k;
    int r;
    logic [15:0] code;
    logic [63:0] val;
    start = sent_count;
    while (sent_count - start < n_items) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        repeat ($urandom_range(1, 8))
          send_req(CMD_TICK, 6'($urandom_range(47)), {$urandom, $urandom});
      end else if (pick < 55) begin
        k = ($urandom_range(9) == 0) ? HALT_IDX : $urandom_range(HALT_IDX - 1);
        code = 16'(ARM_BASE + k);
        if ($urandom_range(9) != 0) begin
          issue_command(k);
        end else begin
          case ($urandom_range(2))
            0: begin
              send_req(CMD_WRITE, OFF_ARM, 64'(code));
              send_req(CMD_WRITE, OFF_FIRE, 64'(code));
            end
            1: begin
              issue_command(k);
              send_req(CMD_WRITE, OFF_FIRE, 64'(byte_swap(code)));
            end
            default: begin
              send_req(CMD_WRITE, OFF_ARM, {$urandom, $urandom});
              send_req(CMD_WRITE, OFF_FIRE, {$urandom, $urandom});
            end
          endcase
        end
      end else if (pick < 65) begin
        s = $urandom_range(STAGE_COUNT - 1);
        val = ($urandom_range(5) == 0) ? {$urandom, $urandom} : 64'($urandom_range(12));
        send_req(CMD_WRITE, stage_off(s, SUB_TERMINAL), val);
        if ($urandom_range(3) != 0) issue_command(KIND_LOAD * 2 + s);
      end else if (pick < 73) begin
        if ($urandom_range(7) == 0) val = {$urandom, $urandom};
        else val = (64'($urandom_range(3)) << CFG_DIV_LSB) | 64'($urandom_range(7) != 0);
        send_req(CMD_WRITE, OFF_CONFIG, val);
      end else if (pick < 80) begin
        send_req(CMD_WRITE, OFF_STATUS, {$urandom, $urandom});
      end else if (pick < 92) begin
        r = $urandom_range(5);
        send_req(CMD_READ, (r < 4) ? 6'(r * 8) : ((r == 4) ? OFF_CONFIG : OFF_STATUS), '0);
      end else begin
        send_req(2'($urandom_range(2)), 6'($urandom_range(47)), {$urandom, $urandom});
      end
    end
  endtask

  task automatic test_random_traffic();
    idle_pct = 0;  stall_pct = 0;  random_traffic(PHASE_ITEMS);
    idle_pct = 57; stall_pct = 0;  random_traffic(PHASE_ITEMS);
    idle_pct = 0;  stall_pct = 57; random_traffic(PHASE_ITEMS);
    idle_pct = 8;  stall_pct = 8;  random_traffic(PHASE_ITEMS);
  endtask

  // Response ready, stalling at the phase's rate
  always @(posedge clk) begin
    rsp_bus.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  // Compare each accepted response with the oldest prediction
  always @(posedge clk) begin
    wdt_rsp_t want;
    if (rst === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      if (pending_rsp.size() == 0) begin
        $error("response with no request outstanding");
        fail_count++;
      end else begin
        want = pending_rsp.pop_front();
        checked_count++;
        if (rsp_bus.read_value !== want.read_value) begin
          $error("read_value: expected %h, actual %h", want.read_value, rsp_bus.read_value);
          fail_count++;
        end
        if (rsp_bus.timeout_flags !== want.timeout_flags) begin
          $error("timeout_flags: expected %b, actual %b",
                 want.timeout_flags, rsp_bus.timeout_flags);
          fail_count++;
        end
        if (rsp_bus.is_enabled !== want.is_enabled) begin
          $error("is_enabled: expected %b, actual %b", want.is_enabled, rsp_bus.is_enabled);
          fail_count++;
        end
        if (rsp_bus.fire_rejected !== want.fire_rejected) begin
          $error("fire_rejected: expected %b, actual %b",
                 want.fire_rejected, rsp_bus.fire_rejected);
          fail_count++;
        end
      end
    end
  end

  // End the run when no request or response moves for too long
  always @(posedge clk) begin
    if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
        (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout after %0d quiet cycles", quiet_cycles);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst <= 1'b1;
    req_bus.valid <= 1'b0;
    req_bus.cmd <= CMD_TICK;
    req_bus.reg_offset <= '0;
    req_bus.write_value <= '0;

    // Predicted state starts at its reset values
    m_enable = 1'b0;
    m_divider = '0;
    m_prescale = 0;
    m_running = '0;
    m_running[0] = 1'b1;
    m_status = '0;
    m_armed_code = '0;
    m_armed = 1'b0;
    for (int s = 0; s < STAGE_COUNT; s++) begin
      m_term_staged[s] = '0;
      m_term_active[s] = '0;
      m_count[s] = '0;
      m_snap[s] = '0;
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_register_access();
    test_timeout_chain();
    test_commands();
    test_rejected_fires();
    test_ignored_accesses();
    test_random_traffic();
    req_bus.valid <= 1'b0;

    // Drain outstanding responses, then let the pipeline settle
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Covered %0d requests (%0d ticks, %0d writes, %0d reads), %0d responses checked.",
             sent_count, tick_count, write_count, read_count, checked_count);
    $display("Commands run %0d, fires rejected %0d, stage timeouts %0d.",
             fires_run, fires_rejected, stage_timeouts);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/mswdt_pkg.sv
rtl/mswdt_req_if.sv
rtl/mswdt_rsp_if.sv
rtl/mswdt_fire.sv
rtl/multistage_watchdog_timer.sv
bench/tb_multistage_watchdog_timer.sv
